@@ rtl/dmmt_pkg.sv @@
// ----------------------------------------------------------------------------
// dmmt_pkg
// Shared widths, codes and helpers of the maximal munch DFA tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dmmt_pkg;

  localparam int STATE_COUNT  = 64;
  localparam int SYMBOL_COUNT = 256;

  localparam int ACT_W   = 2;
  localparam int STATE_W = 6;
  localparam int SYM_W   = 8;
  localparam int KIND_W  = 3;

  localparam int STATE_AW  = $clog2(STATE_COUNT);
  localparam int SYM_AW    = $clog2(SYMBOL_COUNT);
  localparam int TBL_AW    = STATE_AW + SYM_AW;
  localparam int TBL_DEPTH = 2 ** TBL_AW;
  localparam int ENTRY_W   = STATE_W + 1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_INITIAL_STATE = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_WR_TRANS,
    ACT_WR_MARK,
    ACT_CHAR,
    ACT_END
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD,
    KIND_EXTEND,
    KIND_TOKEN,
    KIND_ERROR,
    KIND_ACCEPT,
    KIND_REJECT
  } kind_t;

  function automatic logic state_ok(input logic [STATE_W-1:0] s);
    return 32'(s) < STATE_COUNT;
  endfunction

  function automatic logic lookup_ok(input logic [STATE_W-1:0] s, input logic [SYM_W-1:0] c);
    return (32'(s) < STATE_COUNT) && (32'(c) < SYMBOL_COUNT);
  endfunction

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [STATE_W-1:0] s,
                                                 input logic [SYM_W-1:0] c);
    return {STATE_AW'(s), SYM_AW'(c)};
  endfunction

endpackage

`default_nettype wire

@@ rtl/dmmt_if.sv @@
// ----------------------------------------------------------------------------
// dmmt_if
// Item and result channels of the tokenizer, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmmt_in_if import dmmt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [STATE_W-1:0] from_state;
  logic [SYM_W-1:0]   symbol;
  logic [STATE_W-1:0] to_state;
  logic               entry_flag;

  modport source (output valid, action, from_state, symbol, to_state, entry_flag,
                  input ready);
  modport sink   (input valid, action, from_state, symbol, to_state, entry_flag,
                  output ready);
endinterface

interface dmmt_out_if import dmmt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [SYM_W-1:0]   echo_char;
  logic [STATE_W-1:0] dfa_state;

  modport source (output valid, kind, echo_char, dfa_state, input ready);
  modport sink   (input valid, kind, echo_char, dfa_state, output ready);
endinterface

`default_nettype wire

@@ rtl/dfa_maximal_munch_tokenizer.sv @@
// ----------------------------------------------------------------------------
// dfa_maximal_munch_tokenizer
// DFA scanner with simplified maximal munch, transition table in block RAM.
// ----------------------------------------------------------------------------
// in_ch carries load items (transition or accepting mark writes), characters
// and end-of-string items; out_ch returns exactly one result per item, in
// order. initial_state is written over the APB-style port at address 0.
// A result passes through the lookup stage into the output register. One
// item per cycle is taken while characters extend tokens and out_ch does
// not stall; a character that ends a token stays longer in the lookup stage,
// as the table is read again from initial_state via the single RAM read port.
// After reset the transition table is swept clean, one entry per cycle, over
// all TBL_DEPTH (16384) entries; in_ch.ready stays low meanwhile, config writes
// are taken. Accepting marks sit in flops and clear at once.
// When out_ch stalls, one result waits in the output register and one item
// in the lookup stage, then in_ch.ready drops until the result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_maximal_munch_tokenizer import dmmt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dmmt_in_if.sink           in_ch,
  dmmt_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [STATE_W-1:0]     init_r;
  logic [STATE_W-1:0]     cur_r, cur_nxt, cur_upd;
  logic                   at_start_r, at_start_nxt, at_start_upd;
  logic                   failed_r, failed_nxt, failed_upd;
  logic [STATE_COUNT-1:0] mark_r;
  logic                   clr_busy_r;
  logic [TBL_AW-1:0]      clr_addr_r;

  logic                   s1_valid_r;
  action_t                s1_act_r;
  logic [SYM_W-1:0]       s1_sym_r;
  logic                   s1_retry_r;
  logic                   s1_ok_r;
  logic                   s1_ok_nxt;

  logic                   out_valid_r;
  kind_t                  out_kind_r;
  logic [SYM_W-1:0]       out_echo_r;
  logic [STATE_W-1:0]     out_state_r;

  logic                   ram_we, ram_re;
  logic [TBL_AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;

  action_t                in_act;
  logic                   in_fire, cfg_wr;
  logic [STATE_W-1:0]     eff_state, eff_nxt, shown;
  logic                   eff_acc, hit, need_retry, retry_issue, s1_done, out_free;
  kind_t                  kind;
  logic [SYM_W-1:0]       echo;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (paddr[CFG_AW-1] == REG_INITIAL_STATE) ? CFG_DW'(init_r) : '0;

  assign in_act  = action_t'(in_ch.action);
  assign in_fire = in_ch.valid && in_ch.ready;

  // lookup stage decision
  assign eff_state = at_start_r ? init_r : cur_r;
  assign eff_acc   = state_ok(eff_state) && mark_r[STATE_AW'(eff_state)];
  assign hit       = s1_ok_r && ram_rdata[ENTRY_W-1];

  always_comb begin
    need_retry   = 1'b0;
    kind         = KIND_LOAD;
    echo         = s1_sym_r;
    cur_upd      = cur_r;
    at_start_upd = at_start_r;
    failed_upd   = failed_r;
    unique case (s1_act_r) inside
      ACT_WR_TRANS, ACT_WR_MARK: begin
        kind = KIND_LOAD;
      end
      ACT_CHAR: begin
        cur_upd      = eff_state;
        at_start_upd = 1'b0;
        if (failed_r) begin
          kind = KIND_ERROR;
        end else if (hit) begin
          cur_upd = ram_rdata[STATE_W-1:0];
          kind    = s1_retry_r ? KIND_TOKEN : KIND_EXTEND;
        end else if (!s1_retry_r && eff_acc) begin
          need_retry = 1'b1;
        end else begin
          failed_upd = 1'b1;
          kind       = KIND_ERROR;
        end
      end
      ACT_END: begin
        kind         = (!failed_r && eff_acc) ? KIND_ACCEPT : KIND_REJECT;
        echo         = '0;
        cur_upd      = init_r;
        failed_upd   = 1'b0;
        at_start_upd = 1'b1;
      end
      default: begin
        kind = KIND_LOAD;
      end
    endcase
  end

  assign shown       = at_start_upd ? init_r : cur_upd;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign retry_issue = s1_valid_r && need_retry;
  assign s1_done     = s1_valid_r && !need_retry && out_free;

  assign cur_nxt      = s1_done ? cur_upd      : cur_r;
  assign at_start_nxt = s1_done ? at_start_upd : at_start_r;
  assign failed_nxt   = s1_done ? failed_upd   : failed_r;
  assign eff_nxt      = at_start_nxt ? init_r : cur_nxt;

  assign in_ch.ready = !clr_busy_r && (!s1_valid_r || s1_done);

  // table access: sweep, load write, character read or retry read
  assign ram_re    = retry_issue || (in_fire && in_act == ACT_CHAR);
  assign ram_raddr = retry_issue ? tbl_addr(init_r, s1_sym_r) : tbl_addr(eff_nxt, in_ch.symbol);
  assign s1_ok_nxt = retry_issue ? lookup_ok(init_r, s1_sym_r)
                                 : lookup_ok(eff_nxt, in_ch.symbol);

  assign ram_we    = clr_busy_r ||
                     (in_fire && in_act == ACT_WR_TRANS &&
                      lookup_ok(in_ch.from_state, in_ch.symbol));
  assign ram_waddr = clr_busy_r ? clr_addr_r : tbl_addr(in_ch.from_state, in_ch.symbol);
  assign ram_wdata = (!clr_busy_r && in_ch.entry_flag) ? {1'b1, in_ch.to_state} : '0;

  dmmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= '0;
      cur_r       <= '0;
      at_start_r  <= 1'b1;
      failed_r    <= 1'b0;
      mark_r      <= '0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      s1_retry_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && paddr[CFG_AW-1] == REG_INITIAL_STATE) begin
        init_r <= pwdata[STATE_W-1:0];
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      cur_r      <= cur_nxt;
      at_start_r <= at_start_nxt;
      failed_r   <= failed_nxt;
      if (in_fire && in_act == ACT_WR_MARK && state_ok(in_ch.from_state)) begin
        mark_r[STATE_AW'(in_ch.from_state)] <= in_ch.entry_flag;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        s1_retry_r <= 1'b0;
      end else begin
        if (s1_done) begin
          s1_valid_r <= 1'b0;
          s1_retry_r <= 1'b0;
        end
        if (retry_issue) begin
          s1_retry_r <= 1'b1;
        end
      end
      if (s1_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      s1_act_r <= in_act;
      s1_sym_r <= in_ch.symbol;
    end
    if (ram_re) begin
      s1_ok_r <= s1_ok_nxt;
    end
    if (s1_done) begin
      out_kind_r  <= kind;
      out_echo_r  <= echo;
      out_state_r <= shown;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_kind_r;
  assign out_ch.echo_char = out_echo_r;
  assign out_ch.dfa_state = out_state_r;

`ifndef SYNTHESIS
  a_no_item_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ch.ready)
    else $error("item taken during table sweep");

  a_retry_is_char: assert property (@(posedge clk) disable iff (!rst_n)
    s1_retry_r |-> (s1_valid_r && s1_act_r == ACT_CHAR))
    else $error("retry phase without a character in the lookup stage");

  a_retry_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    retry_issue |-> !ram_we)
    else $error("table write during retry read");

  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_done |=> out_valid_r)
    else $error("finished item did not reach the output register");
`endif

endmodule

`default_nettype wire

@@ rtl/dmmt_ram.sv @@
// ----------------------------------------------------------------------------
// dmmt_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dmmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
